/* hdl/prl_pkg.sv */
package prl_pkg;

   // Number of record cells in the chain.
   localparam int CAPACITY = 128;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths of the channels.
   localparam int FUNC_W  = 2;
   localparam int POS_W   = 8;
   localparam int KEY_W   = 31;
   localparam int AGE_W   = 8;
   localparam int HNDL_W  = 64;
   localparam int STAT_W  = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_SEARCH = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic              sex;
      logic [AGE_W-1:0]  age;
      logic [HNDL_W-1:0] name;
      logic [HNDL_W-1:0] major;
   } record_type;

   typedef struct packed {
      status_type        status;
      logic [POS_W-1:0]  found_position;
      logic [POS_W-1:0]  list_length;
      record_type        rec;
   } result_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic             insert;
      logic             delete_op;
      logic             rotate;
      logic [IDX_W-1:0] first;
   } cell_ctl_type;

endpackage

/* hdl/prl_if.sv */
interface prl_req_if;
   import prl_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [POS_W-1:0]  position;
   logic [KEY_W-1:0]  key;
   logic              sex_bit;
   logic [AGE_W-1:0]  age_value;
   logic [HNDL_W-1:0] name_handle;
   logic [HNDL_W-1:0] major_handle;

   modport source (output valid, func, position, key, sex_bit, age_value, name_handle,
                   major_handle, input ready);
   modport sink (input valid, func, position, key, sex_bit, age_value, name_handle,
                 major_handle, output ready);
endinterface

interface prl_rsp_if;
   import prl_pkg::*;

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [POS_W-1:0]  found_position;
   logic [POS_W-1:0]  list_length;
   logic [KEY_W-1:0]  out_key;
   logic              out_sex;
   logic [AGE_W-1:0]  out_age;
   logic [HNDL_W-1:0] out_name;
   logic [HNDL_W-1:0] out_major;

   modport source (output valid, status, found_position, list_length, out_key, out_sex,
                   out_age, out_name, out_major, input ready);
   modport sink (input valid, status, found_position, list_length, out_key, out_sex,
                 out_age, out_name, out_major, output ready);
endinterface

/* hdl/positional_record_list.sv */
// Channel   Direction  Contents
// req_ch    in         func, position, key, sex_bit, age_value, name_handle, major_handle
// rsp_ch    out        status, found_position, list_length, out_key, out_sex, out_age,
//                      out_name, out_major
//
// An insert or delete moves the cells from the target position onward at the accepting
// edge. A search, or a read inside the list, then rotates the ring past the single compare
// and capture point at cell 0; a full turn leaves the list as it was. Each result enters a
// holding register at the edge that finishes the item and moves on to the output register
// once that is free. The input closes while the ring rotates or the holding register is
// full, so a stalled result in the output register still lets the next item be taken and
// worked on. Reset clears the length, the sequencer state and the handshake state only; the
// cells are never cleared.
module positional_record_list (
   input  logic      clock,
   input  logic      reset,
   prl_req_if.sink   req_ch,
   prl_rsp_if.source rsp_ch
);
   import prl_pkg::*;

   cell_ctl_type ctl;
   record_type   fresh_rec;
   record_type   cell_rec [CAPACITY];

   // The record an insert places into the list comes straight from the request.
   assign fresh_rec.key   = req_ch.key;
   assign fresh_rec.sex   = req_ch.sex_bit;
   assign fresh_rec.age   = req_ch.age_value;
   assign fresh_rec.name  = req_ch.name_handle;
   assign fresh_rec.major = req_ch.major_handle;

   // The sequencer owns the length, the handshakes and the rotation count.
   prl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .head_rec (cell_rec[0]),
      .ctl      (ctl)
   );

   // The cells form a ring: the last cell's right neighbour is cell 0, which is
   // what lets a rotation bring every entry to the head in turn.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      prl_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .my_index  (IDX_W'(g)),
         .left_rec  ((g == 0) ? fresh_rec : cell_rec[(g == 0) ? 0 : g - 1]),
         .right_rec (cell_rec[(g + 1) % CAPACITY]),
         .fresh_rec (fresh_rec),
         .rec       (cell_rec[g])
      );
   end

endmodule

/* hdl/prl_cell.sv */
module prl_cell (
   input  logic                   clock,
   input  prl_pkg::cell_ctl_type  ctl,
   input  logic [prl_pkg::IDX_W-1:0] my_index,
   input  prl_pkg::record_type    left_rec,
   input  prl_pkg::record_type    right_rec,
   input  prl_pkg::record_type    fresh_rec,
   output prl_pkg::record_type    rec
);
   import prl_pkg::*;

   record_type rec_ff;
   record_type rec_in;

   // A rotation pulls from the right neighbour, an insert opens a gap at the
   // target cell, and a delete closes it again from the right.
   always_comb begin
      rec_in = rec_ff;
      if (ctl.rotate) begin
         rec_in = right_rec;
      end else if (ctl.insert) begin
         if (my_index == ctl.first) begin
            rec_in = fresh_rec;
         end else if (my_index > ctl.first) begin
            rec_in = left_rec;
         end
      end else if (ctl.delete_op && (my_index >= ctl.first)) begin
         rec_in = right_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

/* hdl/prl_ctrl.sv */
module prl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   prl_req_if.sink               req_ch,
   prl_rsp_if.source             rsp_ch,
   input  prl_pkg::record_type   head_rec,
   output prl_pkg::cell_ctl_type ctl
);
   import prl_pkg::*;

   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic {
      S_IDLE,
      S_ROTATE
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   logic              search_ff, search_in;
   logic [IDX_W-1:0]  first_ff, first_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              found_ff, found_in;
   logic [CNT_W-1:0]  fpos_ff, fpos_in;
   record_type        rec_ff, rec_in;
   logic              pend_valid_ff, pend_valid_in;
   result_type        pend_ff, pend_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;

   func_type          func;
   logic              accept;
   logic [CMP_W-1:0]  pos_x;
   logic [CMP_W-1:0]  cnt_x;
   logic              pos_ok_ins;
   logic              pos_ok_rd;
   logic              full;
   logic              hit;
   logic              grab;
   logic              last_step;
   logic              out_free;

   assign req_ch.ready = (state_ff == S_IDLE) && !pend_valid_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign func         = func_type'(req_ch.func);

   assign pos_x      = CMP_W'(req_ch.position);
   assign cnt_x      = CMP_W'(count_ff);
   assign pos_ok_ins = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
   assign pos_ok_rd  = (pos_x != '0) && (pos_x <= cnt_x);
   assign full       = (count_ff == CNT_W'(CAPACITY));

   // During a rotation, cell 0 holds the entry whose index equals the step.
   assign last_step = (step_ff == IDX_W'(CAPACITY - 1));
   assign hit  = search_ff && !found_ff && (head_rec.key == key_ff)
                 && (CNT_W'(step_ff) < count_ff);
   assign grab = !search_ff && (step_ff == first_ff);
   assign out_free = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      ctl.insert    = accept && (func == FUNC_INSERT) && pos_ok_ins && !full;
      ctl.delete_op = accept && (func == FUNC_DELETE) && pos_ok_rd;
      ctl.rotate    = (state_ff == S_ROTATE);
      ctl.first     = IDX_W'(req_ch.position - POS_W'(1));
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      search_in     = search_ff;
      first_in      = first_ff;
      key_in        = key_ff;
      found_in      = found_ff;
      fpos_in       = fpos_ff;
      rec_in        = rec_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;

      if (ctl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.delete_op) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (accept) begin
         pend_in.status         = ST_OK;
         pend_in.found_position = '0;
         pend_in.list_length    = POS_W'(count_in);
         pend_in.rec            = '0;
         pend_valid_in          = 1'b1;
         unique case (func)
            FUNC_INSERT: begin
               if (!pos_ok_ins) begin
                  pend_in.status = ST_RANGE;
               end else if (full) begin
                  pend_in.status = ST_FULL;
               end
            end
            FUNC_DELETE: begin
               if (!pos_ok_rd) begin
                  pend_in.status = ST_RANGE;
               end
            end
            FUNC_SEARCH: begin
               if (count_ff == '0) begin
                  pend_in.status = ST_MISS;
               end else begin
                  pend_valid_in = 1'b0;
                  state_in      = S_ROTATE;
               end
            end
            FUNC_READ: begin
               if (!pos_ok_rd) begin
                  pend_in.status = ST_RANGE;
               end else begin
                  pend_valid_in = 1'b0;
                  state_in      = S_ROTATE;
               end
            end
            default: begin
               pend_in.status = ST_OK;
            end
         endcase
         step_in   = '0;
         search_in = (func == FUNC_SEARCH);
         first_in  = ctl.first;
         key_in    = req_ch.key;
         found_in  = 1'b0;
         fpos_in   = '0;
      end

      if (state_ff == S_ROTATE) begin
         step_in = step_ff + IDX_W'(1);
         if (hit) begin
            found_in = 1'b1;
            fpos_in  = CNT_W'(step_ff) + CNT_W'(1);
         end
         if (grab) begin
            rec_in = head_rec;
         end
         if (last_step) begin
            state_in                = S_IDLE;
            pend_valid_in           = 1'b1;
            pend_in.found_position  = POS_W'(fpos_in);
            pend_in.list_length     = POS_W'(count_ff);
            pend_in.rec             = search_ff ? '0 : rec_in;
            pend_in.status          = (search_ff && !found_in) ? ST_MISS : ST_OK;
         end
      end

      if (out_free) begin
         out_valid_in = pend_valid_ff;
         if (pend_valid_ff) begin
            out_in        = pend_ff;
            pend_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      step_ff   <= step_in;
      search_ff <= search_in;
      first_ff  <= first_in;
      key_ff    <= key_in;
      found_ff  <= found_in;
      fpos_ff   <= fpos_in;
      rec_ff    <= rec_in;
      pend_ff   <= pend_in;
      out_ff    <= out_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.status         = out_ff.status;
   assign rsp_ch.found_position = out_ff.found_position;
   assign rsp_ch.list_length    = out_ff.list_length;
   assign rsp_ch.out_key        = out_ff.rec.key;
   assign rsp_ch.out_sex        = out_ff.rec.sex;
   assign rsp_ch.out_age        = out_ff.rec.age;
   assign rsp_ch.out_name       = out_ff.rec.name;
   assign rsp_ch.out_major      = out_ff.rec.major;

endmodule

/* verif/tb_positional_record_list.sv */
`timescale 1ns / 1ps

// Self-checking bench for the positional record list. Commands go in on
// the request channel with random idle gaps. An internal shadow of the list
// predicts the response to every accepted item. A separate process checks
// each response, in order, against the oldest outstanding prediction.
module tb_positional_record_list;
   import prl_pkg::*;

   // No run should come close to this. Searches and reads take a full turn
   // of the ring, and both sides also stall at random.
   localparam int CYCLE_LIMIT   = 1000000;
   // Length of the deliberate response stall in the back-pressure test.
   localparam int PRESSURE_HOLD = 300;
   // Quiet period after the last response, which covers a full rotation.
   localparam int SETTLE_CYCLES = 2 * CAPACITY + 20;

   typedef struct {
      func_type   op;
      int         pos;
      record_type rec;
   } list_cmd_type;

   logic clock;
   logic reset;

   prl_req_if req_ch ();
   prl_rsp_if rsp_ch ();

   positional_record_list uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow of the list contents. Only entries below list_len are ever looked at.
   record_type records [CAPACITY];
   int         list_len;

   // Predicted responses, oldest first.
   result_type pending_results [$];

   int error_count;
   int cycle_count;

   // Sender idling controls.
   bit sender_calm;
   bit gaps_off;

   // Receiver idling controls. The test process asks for a long hold by
   // bumping pressure_req. The receiver process alone counts the hold down.
   int rsp_hold;
   bit rsp_calm;
   int rsp_roll;
   int pressure_req;
   int pressure_ack;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run is stopped if it gets stuck anywhere.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Shadow of the list
   // ---------------------------------------------------------------------

   // This applies one command to the shadow list and returns the response
   // that the block must give for it. Positions are 1-based. Position zero
   // is never valid.
   function automatic result_type run_list_op(input list_cmd_type cmd);
      result_type res;
      res = '0;
      res.status = ST_OK;
      case (cmd.op)
         FUNC_INSERT: begin
            // The range check comes before the full check. An insert just
            // past the last entry is in range even when the store is full.
            if (cmd.pos < 1 || cmd.pos > list_len + 1) begin
               res.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (int i = list_len; i >= cmd.pos; i--) records[i] = records[i-1];
               records[cmd.pos-1] = cmd.rec;
               list_len++;
            end
         end
         FUNC_DELETE: begin
            if (cmd.pos < 1 || cmd.pos > list_len) begin
               res.status = ST_RANGE;
            end else begin
               for (int i = cmd.pos; i < list_len; i++) records[i-1] = records[i];
               list_len--;
            end
         end
         FUNC_SEARCH: begin
            // The first match wins when a key appears more than once.
            for (int i = 0; i < list_len; i++) begin
               if (res.found_position == 0 && records[i].key == cmd.rec.key)
                  res.found_position = POS_W'(i + 1);
            end
            if (res.found_position == 0) res.status = ST_MISS;
         end
         default: begin
            // A read outside the list leaves every record field at zero.
            if (cmd.pos < 1 || cmd.pos > list_len) res.status = ST_RANGE;
            else res.rec = records[cmd.pos-1];
         end
      endcase
      res.list_length = POS_W'(list_len);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic record_type make_rec(input logic [KEY_W-1:0] key, input logic sex,
                                           input logic [AGE_W-1:0] age,
                                           input logic [HNDL_W-1:0] name,
                                           input logic [HNDL_W-1:0] major);
      record_type rec;
      rec.key   = key;
      rec.sex   = sex;
      rec.age   = age;
      rec.name  = name;
      rec.major = major;
      return rec;
   endfunction

   // Half of the keys come from a small pool, so that duplicates appear and
   // searches hit entries other than the one that was aimed at.
   function automatic record_type rand_rec();
      logic [KEY_W-1:0] key;
      if ($urandom_range(0, 1) == 0) key = KEY_W'($urandom_range(0, 31));
      else key = KEY_W'($urandom);
      return make_rec(key, ($urandom_range(0, 1) == 1), AGE_W'($urandom_range(0, 255)),
                      {$urandom, $urandom}, {$urandom, $urandom});
   endfunction

   // This picks a position in 1..top, with the ends favoured. Now and then
   // it picks any position from 0 to 129, to exercise the range checks.
   function automatic int pick_pos(input int top);
      int roll;
      roll = $urandom_range(0, 99);
      if (top < 1 || roll < 10) return $urandom_range(0, 129);
      if (roll < 20) return 1;
      if (roll < 30) return top;
      return $urandom_range(1, top);
   endfunction

   // This mostly picks a key that is known to be stored. Otherwise the key
   // is random and usually misses.
   function automatic record_type search_rec();
      record_type rec;
      rec = rand_rec();
      if (list_len > 0 && $urandom_range(0, 9) < 7)
         rec.key = records[$urandom_range(0, list_len - 1)].key;
      return rec;
   endfunction

   // Most gaps are short. A few are long. Stretches without any gap come and
   // go at random.
   function automatic int sender_gap();
      int roll;
      if (gaps_off) return 0;
      if ($urandom_range(0, 59) == 0) sender_calm = !sender_calm;
      if (sender_calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // This sends one item and waits until the block accepts it. The task is
   // entered and left just after a rising edge. valid stays high on return,
   // so that the next item can follow at once. It is lowered here only
   // when a gap is taken.
   task automatic send_cmd(input func_type op, input int pos, input record_type rec);
      list_cmd_type cmd;
      int           gap;
      gap = sender_gap();
      if (gap > 0) begin
         // Garbage on the payload while idle must be ignored.
         req_ch.valid        <= 1'b0;
         req_ch.func         <= FUNC_W'($urandom);
         req_ch.position     <= POS_W'($urandom);
         req_ch.key          <= KEY_W'($urandom);
         req_ch.name_handle  <= {$urandom, $urandom};
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= op;
      req_ch.position     <= pos[POS_W-1:0];
      req_ch.key          <= rec.key;
      req_ch.sex_bit      <= rec.sex;
      req_ch.age_value    <= rec.age;
      req_ch.name_handle  <= rec.name;
      req_ch.major_handle <= rec.major;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      cmd.op  = op;
      cmd.pos = pos;
      cmd.rec = rec;
      pending_results.push_back(run_list_op(cmd));
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   task automatic compare_field(input string field, input logic [HNDL_W-1:0] want,
                                input logic [HNDL_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   task automatic check_result();
      result_type want;
      if (pending_results.size() == 0) begin
         error_count++;
         $display("%0t: response with no item outstanding, expected none, actual status %0d",
                  $time, rsp_ch.status);
         return;
      end
      want = pending_results.pop_front();
      compare_field("status",         HNDL_W'(want.status),   HNDL_W'(rsp_ch.status));
      compare_field("found_position", HNDL_W'(want.found_position),
                    HNDL_W'(rsp_ch.found_position));
      compare_field("list_length",    HNDL_W'(want.list_length),
                    HNDL_W'(rsp_ch.list_length));
      compare_field("out_key",        HNDL_W'(want.rec.key),  HNDL_W'(rsp_ch.out_key));
      compare_field("out_sex",        HNDL_W'(want.rec.sex),  HNDL_W'(rsp_ch.out_sex));
      compare_field("out_age",        HNDL_W'(want.rec.age),  HNDL_W'(rsp_ch.out_age));
      compare_field("out_name",       want.rec.name,          rsp_ch.out_name);
      compare_field("out_major",      want.rec.major,         rsp_ch.out_major);
   endtask

   // The receiver checks any response taken at this edge and then decides
   // ready for the next cycle. A requested hold overrides everything else.
   // Otherwise ready follows calm stretches or random short and long stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold     = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_result();
         if (pressure_req != pressure_ack) begin
            pressure_ack = pressure_req;
            rsp_hold     = PRESSURE_HOLD;
         end
         if ($urandom_range(0, 299) == 0) rsp_calm = !rsp_calm;
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_calm) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_roll = $urandom_range(0, 99);
            if (rsp_roll < 70) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_ch.ready <= 1'b0;
               // The current cycle is the first cycle of the stall.
               if (rsp_roll < 96) rsp_hold = $urandom_range(0, 2);
               else rsp_hold = $urandom_range(9, 39);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Every operation is tried on an empty list, at its edges and in the
   // middle. The records use the extreme field values.
   task automatic test_directed();
      record_type rec_max, rec_zero, rec_mid, rec_dup;
      rec_max  = make_rec('1, 1'b1, 8'hFF, '1, '1);
      rec_zero = make_rec('0, 1'b0, 8'h00, '0, '0);
      rec_mid  = make_rec(31'h2AAA_AAAA, 1'b0, 8'h55, 64'h5555_5555_5555_5555,
                          64'hAAAA_AAAA_AAAA_AAAA);
      rec_dup  = make_rec('0, 1'b1, 8'hAA, 64'hAAAA_AAAA_AAAA_AAAA,
                          64'h5555_5555_5555_5555);
      // On an empty list everything except an insert at position one fails.
      send_cmd(FUNC_READ,   0, rec_zero);
      send_cmd(FUNC_READ,   1, rec_zero);
      send_cmd(FUNC_DELETE, 1, rec_zero);
      send_cmd(FUNC_SEARCH, 0, rec_zero);
      send_cmd(FUNC_INSERT, 0, rec_max);
      send_cmd(FUNC_INSERT, 2, rec_max);
      // The list is built with inserts at the front, the end and the middle.
      send_cmd(FUNC_INSERT, 1, rec_max);
      send_cmd(FUNC_INSERT, 1, rec_zero);
      send_cmd(FUNC_INSERT, 3, rec_mid);
      send_cmd(FUNC_INSERT, 2, rec_dup);
      send_cmd(FUNC_INSERT, 6, rec_mid);
      // Key zero is held twice, so the search must report the first copy.
      send_cmd(FUNC_SEARCH, 0, rec_zero);
      send_cmd(FUNC_SEARCH, 0, rec_max);
      send_cmd(FUNC_SEARCH, 0, make_rec(31'd12345, 1'b0, '0, '0, '0));
      for (int p = 1; p <= 5; p++) send_cmd(FUNC_READ, p, rec_zero);
      // Deletes out of range, then in the middle, at the end and at the front.
      send_cmd(FUNC_DELETE, 5, rec_zero);
      send_cmd(FUNC_DELETE, 0, rec_zero);
      send_cmd(FUNC_DELETE, 2, rec_zero);
      send_cmd(FUNC_DELETE, 3, rec_zero);
      send_cmd(FUNC_DELETE, 1, rec_zero);
      send_cmd(FUNC_READ,   1, rec_zero);
   endtask

   // The store is filled to capacity with random records at random valid
   // positions. The full and range cases at the top are then tried, and the
   // list is emptied down to a moderate length.
   task automatic test_fill_to_capacity();
      while (list_len < CAPACITY) send_cmd(FUNC_INSERT, $urandom_range(1, list_len + 1),
                                           rand_rec());
      send_cmd(FUNC_INSERT, CAPACITY + 1, rand_rec());
      send_cmd(FUNC_INSERT, 1, rand_rec());
      send_cmd(FUNC_INSERT, 0, rand_rec());
      send_cmd(FUNC_READ,   CAPACITY, rand_rec());
      send_cmd(FUNC_READ,   CAPACITY + 1, rand_rec());
      send_cmd(FUNC_DELETE, CAPACITY + 1, rand_rec());
      send_cmd(FUNC_SEARCH, 0, make_rec(records[CAPACITY-1].key, 1'b0, '0, '0, '0));
      send_cmd(FUNC_READ,   1, rand_rec());
      while (list_len > 40) send_cmd(FUNC_DELETE, $urandom_range(1, list_len), rand_rec());
   endtask

   // The receiver holds off for a long stretch while items are offered back
   // to back. The block's output stages fill and its input must stall.
   // Inserts and deletes are quick, so they make up most of the burst.
   task automatic test_backpressure();
      int roll;
      pressure_req <= pressure_req + 1;
      gaps_off = 1'b1;
      for (int n = 0; n < 40; n++) begin
         roll = $urandom_range(0, 9);
         if (roll < 6) send_cmd(FUNC_INSERT, pick_pos(list_len + 1), rand_rec());
         else if (roll < 9) send_cmd(FUNC_DELETE, pick_pos(list_len), rand_rec());
         else send_cmd(FUNC_READ, pick_pos(list_len), rand_rec());
      end
      gaps_off = 1'b0;
   endtask

   // This sends random well-formed traffic in phases that grow or shrink the
   // list. The length therefore wanders between empty and full.
   task automatic test_random_mix(input int count);
      int  roll;
      int  phase_left;
      bit  growing;
      phase_left = 0;
      growing    = 1'b1;
      for (int n = 0; n < count; n++) begin
         if (phase_left == 0) begin
            growing    = !growing;
            phase_left = $urandom_range(40, 90);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (!growing) roll = (roll < 55) ? 15 + roll : roll - 55;
         // Here roll below 55 means insert when growing. When shrinking the
         // remapped roll gives mostly deletes and a few inserts.
         if (roll < 55 && growing || roll < 15)
            send_cmd(FUNC_INSERT, pick_pos(list_len + 1), rand_rec());
         else if (roll < 70)
            send_cmd(FUNC_DELETE, pick_pos(list_len), rand_rec());
         else if (roll < 85)
            send_cmd(FUNC_SEARCH, $urandom_range(0, 129), search_rec());
         else
            send_cmd(FUNC_READ, pick_pos(list_len), rand_rec());
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.func         <= FUNC_INSERT;
      req_ch.position     <= '0;
      req_ch.key          <= '0;
      req_ch.sex_bit      <= 1'b0;
      req_ch.age_value    <= '0;
      req_ch.name_handle  <= '0;
      req_ch.major_handle <= '0;
      pressure_req        <= 0;
      list_len            = 0;
      sender_calm         = 1'b0;
      gaps_off            = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_to_capacity();
      test_backpressure();
      test_random_mix(460);

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // Any late or extra response would show up during this wait.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/prl_pkg.sv
hdl/prl_if.sv
hdl/prl_cell.sv
hdl/prl_ctrl.sv
hdl/positional_record_list.sv
verif/tb_positional_record_list.sv
